// ===== src/mld_pkg.sv =====
// ----------------------------------------------------------------------------
// mld_pkg
// Shared widths, request and register codes, and the controller/datapath
// command and status bundles of the minimum-latency delay queue.
// ----------------------------------------------------------------------------
package mld_pkg;

  // Field widths of the channels
  localparam int REQ_W      = 2;
  localparam int DATA_W     = 32;
  localparam int LAT_W      = 8;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Request codes; any other code is a status query
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STATUS = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LATENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // latch an input transaction
    logic cfg_write;  // apply a configuration transaction
    logic rd_head;    // read the head slot instead of the tail slot
    logic exec;       // perform the push or pop
    logic pad;        // append a bubble after a pop if short
    logic load_out;   // load the result register
    logic fill;       // append one bubble while raising the minimum
    logic trim;       // retire one tail bubble while lowering the minimum
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic item_pop;     // latched request is a pop
    logic min_up;       // pending write raises the minimum length
    logic min_down;     // pending write lowers the minimum length
    logic fill_more;    // queue is still below the minimum
    logic trim_more;    // queue is still above the minimum
    logic tail_bubble;  // slot read at the tail is a bubble
    logic out_free;     // result register can take a new result
  } ctrl_sts_t;

endpackage

// ===== src/mld_req_if.sv =====
// ----------------------------------------------------------------------------
// mld_req_if
// Request channel: push, pop or status query with the pushed payload word.
// ----------------------------------------------------------------------------
interface mld_req_if import mld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] push_payload;

  modport source (output valid, output req_type, output push_payload, input ready);
  modport sink   (input valid, input req_type, input push_payload, output ready);
endinterface

// ===== src/mld_resp_if.sv =====
// ----------------------------------------------------------------------------
// mld_resp_if
// Response channel: one status transaction for every request transaction.
// ----------------------------------------------------------------------------
interface mld_resp_if import mld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pop_valid;
  logic [DATA_W-1:0] pop_payload;
  logic              push_rejected;
  logic              queue_full;
  logic              queue_empty;
  logic [LEN_W-1:0]  payload_count;
  logic [LEN_W-1:0]  total_length;

  modport source (output valid, output pop_valid, output pop_payload,
                  output push_rejected, output queue_full, output queue_empty,
                  output payload_count, output total_length, input ready);
  modport sink   (input valid, input pop_valid, input pop_payload,
                  input push_rejected, input queue_full, input queue_empty,
                  input payload_count, input total_length, output ready);
endinterface

// ===== src/mld_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mld_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mld_cfg_if import mld_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/mld_ram.sv =====
// ----------------------------------------------------------------------------
// mld_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mld_ctrl.sv =====
// ----------------------------------------------------------------------------
// mld_ctrl
// Sequencer of the delay queue: steps one request or one configuration
// write through read, execute, pad for a pop, and respond, or fill and trim.
// ----------------------------------------------------------------------------
module mld_ctrl import mld_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_EXEC     = 3'd2;
  localparam logic [2:0] S_PAD      = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;
  localparam logic [2:0] S_FILL     = 3'd5;
  localparam logic [2:0] S_TRIM_RD  = 3'd6;
  localparam logic [2:0] S_TRIM_CHK = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // Configuration takes priority over a request in idle
  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && !cfg_valid;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (sts.min_up) begin
            state_next = S_FILL;
          end else if (sts.min_down) begin
            state_next = S_TRIM_RD;
          end
        end else if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_head = sts.item_pop;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.item_pop ? S_PAD : S_RESP;
      end
      S_PAD: begin
        cmd.pad    = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FILL: begin
        if (sts.fill_more) begin
          cmd.fill = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TRIM_RD: begin
        state_next = sts.trim_more ? S_TRIM_CHK : S_IDLE;
      end
      S_TRIM_CHK: begin
        if (sts.tail_bubble) begin
          cmd.trim   = 1'b1;
          state_next = S_TRIM_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/mld_dp.sv =====
// ----------------------------------------------------------------------------
// mld_dp
// Datapath of the delay queue: slot memory, head and tail pointers, length
// and payload counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module mld_dp import mld_pkg::*; #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32,
  parameter int COUNT_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [DATA_W-1:0]     push_payload,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  resp_ready,
  output logic                  resp_valid,
  output logic                  pop_valid,
  output logic [DATA_W-1:0]     pop_payload,
  output logic                  push_rejected,
  output logic                  queue_full,
  output logic                  queue_empty,
  output logic [LEN_W-1:0]      payload_count,
  output logic [LEN_W-1:0]      total_length
);

  localparam int IW   = $clog2(DEPTH);
  localparam int LW   = $clog2(DEPTH + 1);
  localparam int CMPW = (LW > LEN_W) ? LW : LEN_W;
  localparam int PW   = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
  localparam int CW   = COUNT_BITS;
  localparam int EW   = 1 + CW + PW;
  localparam logic [IW-1:0]   LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(DEPTH);

  // Control registers
  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic [LW-1:0]    length;
  logic [LW-1:0]    held;
  logic [LAT_W-1:0] lat_reg;
  logic [LEN_W-1:0] min_len;
  logic [LEN_W-1:0] max_len;
  logic             pad_ok;

  // Payload registers
  logic [REQ_W-1:0] req_q;
  logic [PW-1:0]    pl_q;
  logic             res_pv;
  logic [PW-1:0]    res_pp;
  logic             res_rej;

  // Slot memory port
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          rd_has;
  logic [CW-1:0] rd_cd;
  logic [PW-1:0] rd_pl;

  // Derived values
  logic [CMPW-1:0] len_c;
  logic [CMPW-1:0] min_c;
  logic [CMPW-1:0] max_c;
  logic            is_full;
  logic            len_zero;
  logic [IW-1:0]   next_tail;
  logic [IW-1:0]   prev_tail;
  logic [IW-1:0]   next_head;
  logic [CW-1:0]   lat_cw;
  logic            below_min;
  logic            push_ok;
  logic            push_over;
  logic            push_app;
  logic            pop_go;
  logic            pop_dec;
  logic            pop_rm;
  logic            bubble_app;
  logic            held_dec;

  // Slot memory: {has_payload, countdown, payload}
  mld_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_has = rdata[EW-1];
  assign rd_cd  = rdata[PW +: CW];
  assign rd_pl  = rdata[PW-1:0];
  assign raddr  = cmd.rd_head ? head : tail;

  // Compare lengths at a common width
  assign len_c     = CMPW'(length);
  assign min_c     = CMPW'(min_len);
  assign max_c     = CMPW'(max_len);
  assign is_full   = (len_c >= DEPTH_C) || ((max_len != '0) && (len_c >= max_c));
  assign len_zero  = (length == '0);
  assign below_min = (len_c < min_c) && (len_c < DEPTH_C);
  assign lat_cw    = CW'(lat_reg);

  // Circular pointer steps
  assign next_tail = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign prev_tail = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign next_head = (head == LAST_IDX) ? '0 : head + 1'b1;

  // Decode the queue operation of this cycle
  assign push_ok    = cmd.exec && (req_q == REQ_PUSH) && !is_full;
  assign push_over  = push_ok && !len_zero && !rd_has && (len_c >= min_c);
  assign push_app   = push_ok && !push_over;
  assign pop_go     = cmd.exec && (req_q == REQ_POP) && !len_zero;
  assign pop_dec    = pop_go && (rd_cd != '0);
  assign pop_rm     = pop_go && (rd_cd == '0);
  assign bubble_app = (cmd.pad && pad_ok && (min_len != '0) && below_min) || cmd.fill;
  assign held_dec   = pop_rm && rd_has && (held != '0);

  // Select the slot write
  always_comb begin
    we    = 1'b0;
    waddr = tail;
    wdata = {1'b0, lat_cw, {PW{1'b0}}};
    if (push_over) begin
      we    = 1'b1;
      wdata = {1'b1, lat_cw, pl_q};
    end else if (push_app) begin
      we    = 1'b1;
      waddr = next_tail;
      wdata = {1'b1, lat_cw, pl_q};
    end else if (pop_dec) begin
      we    = 1'b1;
      waddr = head;
      wdata = {rd_has, rd_cd - 1'b1, rd_pl};
    end else if (bubble_app) begin
      we    = 1'b1;
      waddr = next_tail;
    end
  end

  // Advance pointers, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= LAST_IDX;
      length     <= '0;
      held       <= '0;
      lat_reg    <= '0;
      min_len    <= '0;
      max_len    <= '0;
      pad_ok     <= 1'b0;
      resp_valid <= 1'b0;
    end else begin
      if (push_app || bubble_app) begin
        tail   <= next_tail;
        length <= length + 1'b1;
      end else if (cmd.trim) begin
        tail   <= prev_tail;
        length <= length - 1'b1;
      end else if (pop_rm) begin
        head   <= next_head;
        length <= length - 1'b1;
      end
      if (push_ok) begin
        held <= held + 1'b1;
      end else if (held_dec) begin
        held <= held - 1'b1;
      end
      if (cmd.exec) begin
        pad_ok <= pop_go;
      end
      if (cmd.cfg_write) begin
        case (cfg_index)
          REG_ENTRY_LATENCY: lat_reg <= cfg_data;
          REG_MIN_LENGTH:    min_len <= cfg_data[LEN_W-1:0];
          REG_MAX_LENGTH:    max_len <= cfg_data[LEN_W-1:0];
          default:           ;
        endcase
      end
      if (cmd.load_out) begin
        resp_valid <= 1'b1;
      end else if (resp_ready) begin
        resp_valid <= 1'b0;
      end
    end
  end

  // Capture the request, the pop result and the response fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req_type;
      pl_q  <= push_payload[PW-1:0];
    end
    if (cmd.exec) begin
      res_rej <= (req_q == REQ_PUSH) && is_full;
      res_pv  <= pop_rm && rd_has;
      res_pp  <= (pop_rm && rd_has) ? rd_pl : '0;
    end
    if (cmd.load_out) begin
      pop_valid     <= res_pv;
      pop_payload   <= DATA_W'(res_pp);
      push_rejected <= res_rej;
      queue_full    <= is_full;
      queue_empty   <= len_zero;
      payload_count <= LEN_W'(held);
      total_length  <= LEN_W'(length);
    end
  end

  // Status to the controller
  always_comb begin
    sts.item_pop    = (req_q == REQ_POP);
    sts.min_up      = (cfg_index == REG_MIN_LENGTH) && (cfg_data[LEN_W-1:0] > min_len);
    sts.min_down    = (cfg_index == REG_MIN_LENGTH) && (cfg_data[LEN_W-1:0] < min_len);
    sts.fill_more   = below_min;
    sts.trim_more   = (len_c > min_c);
    sts.tail_bubble = !rd_has;
    sts.out_free    = !resp_valid || resp_ready;
  end

endmodule

// ===== src/min_latency_delay_fifo.sv =====
// ----------------------------------------------------------------------------
// min_latency_delay_fifo
// Circular queue of payload and bubble slots, padded with bubbles to a
// minimum length, where each slot must be popped entry_latency extra times.
//
// Usage:
//   req  : push (0), pop (1) or status query (2 or 3) with a payload word.
//   resp : exactly one status transaction for each request transaction.
//   cfg  : register writes (0 entry_latency, 1 min_length, 2 max_length),
//          issued only while no request is outstanding.
// Timing: one request at a time through a slot memory with one write port,
//   one read port and a registered read. A request steps through read,
//   execute, bubble pad (pops only) and respond, where its result is loaded;
//   the next request can be accepted in the cycle after the response is
//   loaded, so a new request is not taken while one is in progress.
// A result waits in the output register; while the receiver stalls, one more
//   request is taken and holds in the respond step, and then nothing new is
//   accepted until the waiting result leaves.
// Raising min_length appends one bubble per cycle; lowering it reads the
//   tail slot and retires it while it is a bubble. Reset empties the queue
//   and clears the control registers; no memory clearing is needed.
// ----------------------------------------------------------------------------
module min_latency_delay_fifo import mld_pkg::*; #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32,
  parameter int COUNT_BITS   = 8
) (
  input logic         clk,
  input logic         rst,
  mld_req_if.sink     req,
  mld_resp_if.source  resp,
  mld_cfg_if.sink     cfg
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  mld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Queue storage and result register
  mld_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req.req_type),
    .push_payload  (req.push_payload),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .resp_ready    (resp.ready),
    .resp_valid    (resp.valid),
    .pop_valid     (resp.pop_valid),
    .pop_payload   (resp.pop_payload),
    .push_rejected (resp.push_rejected),
    .queue_full    (resp.queue_full),
    .queue_empty   (resp.queue_empty),
    .payload_count (resp.payload_count),
    .total_length  (resp.total_length)
  );

endmodule

// ===== sim/tb_min_latency_delay_fifo.sv =====
// ----------------------------------------------------------------------------
// tb_min_latency_delay_fifo
// Self-checking bench for the minimum-latency delay queue. An in-bench model
// of the queue (slots, countdowns, bubble padding, length limits) predicts
// the status of every request transaction. Results are checked field by
// field in order. The run covers directed corner cases, a long receiver
// hold-off, and random traffic phases over several register settings and
// idle patterns.
// ----------------------------------------------------------------------------
module tb_min_latency_delay_fifo;
  timeunit 1ns;
  timeprecision 1ps;
  import mld_pkg::*;

  localparam int SLOTS          = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 20;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 60;

  // The fourth request code is unused and acts as a status query
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic              pop_valid;
    logic [DATA_W-1:0] pop_payload;
    logic              push_rejected;
    logic              queue_full;
    logic              queue_empty;
    logic [LEN_W-1:0]  payload_count;
    logic [LEN_W-1:0]  total_length;
  } fifo_status_t;

  logic clk;
  logic rst;

  mld_req_if  req_if ();
  mld_resp_if resp_if ();
  mld_cfg_if  cfg_if ();

  min_latency_delay_fifo DUT (
    .clk  (clk),
    .rst  (rst),
    .req  (req_if),
    .resp (resp_if),
    .cfg  (cfg_if)
  );

  // Queue model state
  logic [DATA_W-1:0] slot_word [SLOTS];
  logic              slot_full [SLOTS];
  logic [LAT_W-1:0]  slot_wait [SLOTS];
  int                head_at;
  int                tail_at;
  int                fill_len;
  int                held_cnt;
  logic [LAT_W-1:0]  lat_cfg;
  int                min_cfg;
  int                max_cfg;

  fifo_status_t status_due [$];
  int           mismatches = 0;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic         hold_toggle;
  int           quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Queue model
  // ---------------------------------------------------------------------------
  function automatic logic queue_at_limit();
    return (fill_len >= SLOTS) || (max_cfg != 0 && fill_len >= max_cfg);
  endfunction

  function automatic void load_tail(input logic has, input logic [DATA_W-1:0] word);
    slot_full[tail_at] = has;
    slot_word[tail_at] = has ? word : '0;
    slot_wait[tail_at] = lat_cfg;
  endfunction

  function automatic void append_slot(input logic has, input logic [DATA_W-1:0] word);
    if (fill_len >= SLOTS) return;
    tail_at = (tail_at + 1) % SLOTS;
    fill_len++;
    load_tail(has, word);
    if (has) held_cnt++;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
    int v;
    v = int'(value[LEN_W-1:0]);
    case (idx)
      REG_ENTRY_LATENCY: lat_cfg = value;
      REG_MIN_LENGTH: begin
        // Grow with bubbles, or shed trailing bubbles down to the new minimum
        if (v > min_cfg) begin
          min_cfg = v;
          while (fill_len < min_cfg && fill_len < SLOTS) append_slot(1'b0, '0);
        end else if (v < min_cfg) begin
          min_cfg = v;
          while (fill_len > min_cfg && !slot_full[tail_at]) begin
            tail_at = (tail_at + SLOTS - 1) % SLOTS;
            fill_len--;
          end
        end
      end
      REG_MAX_LENGTH: max_cfg = v;
      default: ;
    endcase
  endfunction

  function automatic fifo_status_t predict_status(input logic [REQ_W-1:0] kind,
                                                  input logic [DATA_W-1:0] word);
    fifo_status_t st;
    st = '0;
    case (kind)
      REQ_PUSH: begin
        // Reject if full, overwrite a tail bubble once length >= min, else append
        if (queue_at_limit()) begin
          st.push_rejected = 1'b1;
        end else if (fill_len != 0 && !slot_full[tail_at] && fill_len >= min_cfg) begin
          load_tail(1'b1, word);
          held_cnt++;
        end else begin
          append_slot(1'b1, word);
        end
      end
      REQ_POP: begin
        if (fill_len != 0) begin
          // Spend the head countdown first, then retire the head
          if (slot_wait[head_at] != 0) begin
            slot_wait[head_at] = slot_wait[head_at] - 1'b1;
          end else begin
            if (slot_full[head_at]) begin
              st.pop_valid   = 1'b1;
              st.pop_payload = slot_word[head_at];
              if (held_cnt != 0) held_cnt--;
            end
            slot_full[head_at] = 1'b0;
            head_at = (head_at + 1) % SLOTS;
            fill_len--;
          end
          if (min_cfg != 0 && fill_len < min_cfg) append_slot(1'b0, '0);
        end
      end
      default: ;
    endcase
    st.queue_full    = queue_at_limit();
    st.queue_empty   = (fill_len == 0);
    st.payload_count = LEN_W'(held_cnt);
    st.total_length  = LEN_W'(fill_len);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted status transaction with the oldest prediction
  always @(posedge clk) begin
    fifo_status_t want;
    if (!rst && resp_if.valid && resp_if.ready) begin
      if (status_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: status transaction with nothing pending, expected none, actual 0x%0h",
                   $time, {resp_if.pop_valid, resp_if.pop_payload, resp_if.push_rejected,
                           resp_if.queue_full, resp_if.queue_empty, resp_if.payload_count,
                           resp_if.total_length});
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("pop_valid", DATA_W'(want.pop_valid), DATA_W'(resp_if.pop_valid));
        check_field("pop_payload", want.pop_payload, resp_if.pop_payload);
        check_field("push_rejected", DATA_W'(want.push_rejected),
                    DATA_W'(resp_if.push_rejected));
        check_field("queue_full", DATA_W'(want.queue_full), DATA_W'(resp_if.queue_full));
        check_field("queue_empty", DATA_W'(want.queue_empty), DATA_W'(resp_if.queue_empty));
        check_field("payload_count", DATA_W'(want.payload_count),
                    DATA_W'(resp_if.payload_count));
        check_field("total_length", DATA_W'(want.total_length),
                    DATA_W'(resp_if.total_length));
      end
    end
  end

  // Abort when no channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("min_latency_delay_fifo verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off each time hold_toggle flips
  initial begin
    logic hold_seen;
    int   hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    resp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle !== hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        resp_if.ready <= 1'b0;
      end else begin
        resp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // Offer one request; valid stays high so back-to-back requests flow
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] word);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.push_payload <= word;
    do @(posedge clk); while (!req_if.ready);
    status_due.push_back(predict_status(kind, word));
  endtask

  // Drop valid and hold until every predicted status has arrived
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg_write(idx, value);
  endtask

  function automatic logic [REQ_W-1:0] pick_kind(input int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return REQ_PUSH;
    r = $urandom_range(99);
    if (r < 90) return REQ_POP;
    if (r < 95) return REQ_STATUS;
    return REQ_UNUSED;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_queue();
    send_req(REQ_STATUS, 32'h0000_0001);
    send_req(REQ_UNUSED, 32'h8000_0000);
    send_req(REQ_POP, '0);
    wait_drain();
  endtask

  task automatic test_push_pop_extremes();
    send_req(REQ_PUSH, '0);
    send_req(REQ_PUSH, '1);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
    wait_drain();
  endtask

  task automatic test_full_reject();
    write_reg(REG_MAX_LENGTH, 8'd2);
    send_req(REQ_PUSH, 32'h1234_5678);
    send_req(REQ_PUSH, 32'h8765_4321);
    send_req(REQ_PUSH, 32'hDEAD_BEEF);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
    write_reg(REG_MAX_LENGTH, 8'd0);
  endtask

  task automatic test_countdown_padding();
    // Bubbles padded with a pending countdown; push overwrites the tail bubble
    write_reg(REG_ENTRY_LATENCY, 8'd2);
    write_reg(REG_MIN_LENGTH, 8'd3);
    send_req(REQ_PUSH, 32'hA5A5_5A5A);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
    send_req(REQ_POP, '0);
    // Same minimum changes nothing, lower minimum trims tail bubbles
    write_reg(REG_MIN_LENGTH, 8'd3);
    send_req(REQ_STATUS, '0);
    write_reg(REG_MIN_LENGTH, 8'd0);
    send_req(REQ_STATUS, '0);
    wait_drain();
  endtask

  task automatic test_limits_above_depth();
    write_reg(REG_ENTRY_LATENCY, 8'd0);
    write_reg(REG_MIN_LENGTH, 8'd100);
    send_req(REQ_PUSH, 32'h0F0F_F0F0);
    write_reg(REG_MAX_LENGTH, 8'd100);
    send_req(REQ_STATUS, '0);
    send_req(REQ_POP, '0);
    write_reg(REG_MIN_LENGTH, 8'd0);
    send_req(REQ_STATUS, '0);
    write_reg(REG_MAX_LENGTH, 8'd0);
  endtask

  task automatic test_backpressure();
    // Stall the receiver long while requests keep coming, then pause the sender
    write_reg(REG_ENTRY_LATENCY, 8'd0);
    write_reg(REG_MAX_LENGTH, 8'd16);
    set_idling(0);
    hold_toggle <= ~hold_toggle;
    repeat (40) send_req(pick_kind(60), pick_word());
    wait_drain();
    repeat (10) send_req(pick_kind(40), pick_word());
    wait_drain();
  endtask

  task automatic run_phase(input int lat, input int min_len, input int max_len,
                           input int push_pct, input int items, input int mode);
    write_reg(REG_ENTRY_LATENCY, CFG_DATA_W'(lat));
    write_reg(REG_MIN_LENGTH, CFG_DATA_W'(min_len));
    write_reg(REG_MAX_LENGTH, CFG_DATA_W'(max_len));
    set_idling(mode);
    repeat (items) send_req(pick_kind(push_pct), pick_word());
    wait_drain();
  endtask

  task automatic test_random_traffic();
    run_phase(0,   0,  0,  60, 120, 0);
    run_phase(1,   4,  0,  50, 150, 1);
    run_phase(3,   0,  8,  55, 140, 2);
    run_phase(0,  64,  0,  40,  60, 3);
    run_phase(255, 2, 16,  30, 100, 0);
    run_phase(0,  10, 64,  70, 180, 1);
    run_phase(2,   0,  0,  80, 150, 2);
    run_phase(1,  24,  3,  50,  80, 3);
    run_phase(0,   5,  0,  50, 100, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Model matches the reset state: empty queue, all registers zero
    for (int i = 0; i < SLOTS; i++) begin
      slot_word[i] = '0;
      slot_full[i] = 1'b0;
      slot_wait[i] = '0;
    end
    head_at        = 0;
    tail_at        = SLOTS - 1;
    fill_len       = 0;
    held_cnt       = 0;
    lat_cfg        = '0;
    min_cfg        = 0;
    max_cfg        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    rst                 <= 1'b1;
    hold_toggle         <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_STATUS;
    req_if.push_payload <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_ENTRY_LATENCY;
    cfg_if.data         <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_push_pop_extremes();
    test_full_reject();
    test_countdown_padding();
    test_limits_above_depth();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("min_latency_delay_fifo verification clean");
    end else begin
      $display("min_latency_delay_fifo verification failed");
    end
    $finish;
  end

endmodule
